>>> rtl/clq_pkg.sv
// ----------------------------------------------------------------------------
// clq_pkg: shared definitions of the circular queue with search
// Widths, operation and status codes, the default depth and the control
// group that steers the token through the row of queue cells.
// ----------------------------------------------------------------------------
package clq_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int WORD_W    = 32;
   localparam int CAP_W     = 5;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;

   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic load;
      logic shift;
   } tok_ctrl_type;

endpackage

>>> rtl/circular_queue_with_search.sv
// ----------------------------------------------------------------------------
// circular_queue_with_search: circular FIFO of 32-bit words with a search
// A row of queue cells holds the words; a controller keeps the head and tail
// indices and walks a search token from cell to cell.
// ----------------------------------------------------------------------------
// An enqueue, a dequeue or an unused mode leaves busy low, and the result is on
// the rsp_ ports for one cycle right after acceptance, while the next word may
// already be started. A search holds busy high while the token visits one cell
// per cycle and the cells compare, one entry after another, from the oldest
// entry up to a match, the newest entry or DEPTH entries; its result follows
// the last compare. A search of an empty queue leaves busy low and reports no
// match right after acceptance. The receiver cannot stall, and every word must
// be taken when rsp_valid is high. The capacity register is written through
// csr_ and should only change while the queue is idle.
// ----------------------------------------------------------------------------
module circular_queue_with_search #(
   parameter int DEPTH = clq_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [clq_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [clq_pkg::WORD_W-1:0]   req_value,
   output logic                                rsp_valid,
   output logic [clq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [clq_pkg::WORD_W-1:0]   rsp_data_out,
   output logic                                rsp_found,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [clq_pkg::CAP_W-1:0]           csr_data
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CMP_W  = (IDX_W + 1 > clq_pkg::CAP_W) ? IDX_W + 1 : clq_pkg::CAP_W;
   localparam int STEP_W = $clog2(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type                    state_ff;
   logic [IDX_W-1:0]             head_ff;
   logic [IDX_W-1:0]             tail_ff;
   logic                         empty_ff;
   logic [CMP_W-1:0]             cap_ff;
   logic [IDX_W-1:0]             cur_ff;
   logic [STEP_W-1:0]            step_ff;
   logic [clq_pkg::WORD_W-1:0]   key_ff;
   logic                         rsp_valid_ff;
   logic [clq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [clq_pkg::WORD_W-1:0]   rsp_data_ff;
   logic                         rsp_found_ff;

   logic [CMP_W-1:0]             cap_use;
   logic                         accept;
   logic [IDX_W-1:0]             tail_next;
   logic [IDX_W-1:0]             head_next;
   logic [IDX_W-1:0]             cur_next;
   logic                         full;
   logic                         wrap;
   logic                         any_hit;
   logic                         walk_end;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_idx;
   logic [clq_pkg::WORD_W-1:0]   deq_word;
   clq_pkg::tok_ctrl_type        tok_ctrl;

   logic [DEPTH-1:0]                   tok;
   logic [DEPTH-1:0]                   hit;
   logic [DEPTH-1:0]                   head_sel;
   logic [DEPTH-1:0]                   wr_sel;
   logic [DEPTH-1:0]                   tok_from;
   logic [DEPTH-1:0][clq_pkg::WORD_W-1:0] rd_word;

   function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i,
                                                 input logic [CMP_W-1:0] lim);
      logic [CMP_W-1:0] n;
      n = CMP_W'(i) + CMP_W'(1);
      return (n >= lim) ? '0 : i + IDX_W'(1);
   endfunction

   always_comb begin
      if (cap_ff == '0) begin
         cap_use = CMP_W'(1);
      end else if (cap_ff > CMP_W'(DEPTH)) begin
         cap_use = CMP_W'(DEPTH);
      end else begin
         cap_use = cap_ff;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign tail_next = step_idx(tail_ff, cap_use);
   assign head_next = step_idx(head_ff, cap_use);
   assign cur_next  = step_idx(cur_ff, cap_use);
   assign full      = !empty_ff && (tail_next == head_ff);
   assign wrap      = (CMP_W'(cur_ff) + CMP_W'(1)) >= cap_use;
   assign any_hit   = |hit;
   assign walk_end  = (cur_ff == tail_ff) || (step_ff == STEP_W'(DEPTH - 1));

   always_comb begin
      deq_word = '0;
      for (int j = 0; j < DEPTH; j++) begin
         deq_word = deq_word | rd_word[j];
      end
   end

   always_comb begin
      wr_en          = accept && (req_mode == clq_pkg::MODE_ENQUEUE) && !full;
      wr_idx         = empty_ff ? '0 : tail_next;
      tok_ctrl.load  = accept && (req_mode == clq_pkg::MODE_SEARCH);
      tok_ctrl.shift = (state_ff == ST_SEARCH) && !any_hit && !walk_end;
   end

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      assign head_sel[j] = (head_ff == IDX_W'(j));
      assign wr_sel[j]   = wr_en && (wr_idx == IDX_W'(j));
      if (j == 0) begin : g_first
         assign tok_from[j] = wrap;
      end else begin : g_rest
         assign tok_from[j] = tok[j-1] && !wrap;
      end

      clq_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .tok_ctrl     (tok_ctrl),
         .tok_load_bit (head_sel[j]),
         .tok_from     (tok_from[j]),
         .wr_sel       (wr_sel[j]),
         .wr_word      (req_value),
         .key          (key_ff),
         .rd_sel       (head_sel[j]),
         .tok          (tok[j]),
         .hit          (hit[j]),
         .rd_word      (rd_word[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         empty_ff      <= 1'b1;
         cap_ff        <= CMP_W'(DEPTH);
         cur_ff        <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            cap_ff <= CMP_W'(csr_data);
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_status_ff <= clq_pkg::STATUS_DONE;
                  rsp_data_ff   <= '0;
                  rsp_found_ff  <= 1'b0;
                  unique case (req_mode)
                     clq_pkg::MODE_ENQUEUE: begin
                        rsp_valid_ff <= 1'b1;
                        if (empty_ff) begin
                           head_ff  <= '0;
                           tail_ff  <= '0;
                           empty_ff <= 1'b0;
                        end else if (full) begin
                           rsp_status_ff <= clq_pkg::STATUS_FULL;
                        end else begin
                           tail_ff <= tail_next;
                        end
                     end
                     clq_pkg::MODE_DEQUEUE: begin
                        rsp_valid_ff <= 1'b1;
                        if (empty_ff) begin
                           rsp_status_ff <= clq_pkg::STATUS_EMPTY;
                        end else begin
                           rsp_data_ff <= deq_word;
                           if (head_ff == tail_ff) begin
                              head_ff  <= '0;
                              tail_ff  <= '0;
                              empty_ff <= 1'b1;
                           end else begin
                              head_ff <= head_next;
                           end
                        end
                     end
                     clq_pkg::MODE_SEARCH: begin
                        key_ff <= req_value;
                        if (empty_ff) begin
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           cur_ff   <= head_ff;
                           step_ff  <= '0;
                           state_ff <= ST_SEARCH;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_SEARCH: begin
               if (any_hit || walk_end) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= clq_pkg::STATUS_DONE;
                  rsp_data_ff   <= '0;
                  rsp_found_ff  <= any_hit;
                  state_ff      <= ST_IDLE;
               end else begin
                  cur_ff  <= cur_next;
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_found    = rsp_found_ff;

endmodule

>>> rtl/clq_cell.sv
// ----------------------------------------------------------------------------
// clq_cell: one queue slot
// Holds one stored word and one bit of the search token. The token is loaded,
// taken over from the neighboring cell or held, and the cell compares its
// word with the search key while it holds the token.
// ----------------------------------------------------------------------------
module clq_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  clq_pkg::tok_ctrl_type       tok_ctrl,
   input  logic                        tok_load_bit,
   input  logic                        tok_from,
   input  logic                        wr_sel,
   input  logic [clq_pkg::WORD_W-1:0]  wr_word,
   input  logic [clq_pkg::WORD_W-1:0]  key,
   input  logic                        rd_sel,
   output logic                        tok,
   output logic                        hit,
   output logic [clq_pkg::WORD_W-1:0]  rd_word
);

   logic                       tok_ff;
   logic                       tok_in;
   logic [clq_pkg::WORD_W-1:0] word_ff;

   always_comb begin
      if (tok_ctrl.load) begin
         tok_in = tok_load_bit;
      end else if (tok_ctrl.shift) begin
         tok_in = tok_from;
      end else begin
         tok_in = tok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         word_ff <= wr_word;
      end
   end

   assign tok     = tok_ff;
   assign hit     = tok_ff && (word_ff == key);
   assign rd_word = rd_sel ? word_ff : '0;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the circular queue with search
// Directed words cover the empty and full queue, the extreme values, searches
// that hit the oldest and newest entries, and capacity settings out of range.
// Random traffic then runs through phases of different capacities. A shadow
// queue predicts every result word, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH = clq_pkg::DEPTH_DEF;
   localparam int STALL_LIMIT = 1000;
   localparam logic [clq_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [clq_pkg::STATUS_W-1:0] status;
      logic [clq_pkg::WORD_W-1:0]   data_out;
      logic                         found;
   } outcome_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [clq_pkg::MODE_W-1:0]          req_mode = '0;
   logic signed [clq_pkg::WORD_W-1:0]   req_value = '0;
   logic                                rsp_valid;
   logic [clq_pkg::STATUS_W-1:0]        rsp_status;
   logic signed [clq_pkg::WORD_W-1:0]   rsp_data_out;
   logic                                rsp_found;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [clq_pkg::CAP_W-1:0]           csr_data = '0;

   logic [clq_pkg::WORD_W-1:0] shadow_slots [DEPTH];
   int                         shadow_head = 0;
   int                         shadow_tail = 0;
   bit                         shadow_empty = 1'b1;
   logic [clq_pkg::CAP_W-1:0]  shadow_capacity = clq_pkg::CAP_W'(DEPTH);

   outcome_type outcomes_due [$];
   int          fail_count = 0;
   int          stall_cycles = 0;
   bit          gaps_on = 1'b1;

   circular_queue_with_search #(.DEPTH(DEPTH)) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_found    (rsp_found),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int slots_in_use();
      if (shadow_capacity == 0) return 1;
      if (shadow_capacity > DEPTH) return DEPTH;
      return int'(shadow_capacity);
   endfunction

   function automatic int slot_after(input int idx);
      return (idx + 1 >= slots_in_use()) ? 0 : idx + 1;
   endfunction

   function automatic outcome_type queue_outcome(input logic [clq_pkg::MODE_W-1:0] mode,
                                                 input logic [clq_pkg::WORD_W-1:0] word);
      outcome_type res;
      int          idx;
      res = '0;
      res.status = clq_pkg::STATUS_DONE;
      case (mode)
         clq_pkg::MODE_ENQUEUE: begin
            if (shadow_empty) begin
               shadow_head = 0;
               shadow_tail = 0;
               shadow_slots[0] = word;
               shadow_empty = 1'b0;
            end else if (slot_after(shadow_tail) == shadow_head) begin
               res.status = clq_pkg::STATUS_FULL;
            end else begin
               shadow_tail = slot_after(shadow_tail);
               shadow_slots[shadow_tail] = word;
            end
         end
         clq_pkg::MODE_DEQUEUE: begin
            if (shadow_empty) begin
               res.status = clq_pkg::STATUS_EMPTY;
            end else begin
               res.data_out = shadow_slots[shadow_head];
               if (shadow_head == shadow_tail) begin
                  shadow_head = 0;
                  shadow_tail = 0;
                  shadow_empty = 1'b1;
               end else begin
                  shadow_head = slot_after(shadow_head);
               end
            end
         end
         clq_pkg::MODE_SEARCH: begin
            if (!shadow_empty) begin
               idx = shadow_head;
               for (int n = 0; n < DEPTH; n++) begin
                  if (shadow_slots[idx] == word) begin
                     res.found = 1'b1;
                     break;
                  end
                  if (idx == shadow_tail) break;
                  idx = slot_after(idx);
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // The word is held on the req_ ports until the block takes it.
   task automatic send_word(input logic [clq_pkg::MODE_W-1:0] mode,
                            input logic [clq_pkg::WORD_W-1:0] word);
      start <= 1'b1;
      req_mode <= mode;
      req_value <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
      outcomes_due.push_back(queue_outcome(mode, word));
   endtask

   task automatic maybe_pause();
      if (gaps_on && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic write_capacity(input logic [clq_pkg::CAP_W-1:0] cap);
      start <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (4 + $urandom_range(0, 3)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_capacity = cap;
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_queue();
      send_word(clq_pkg::MODE_DEQUEUE, 32'h0000_0000);
      maybe_pause();
      send_word(clq_pkg::MODE_SEARCH, 32'h0000_0000);
      maybe_pause();
      send_word(MODE_UNUSED, 32'hFFFF_FFFF);
      maybe_pause();
   endtask

   // Filling all slots at the reset capacity writes every entry of the store.
   task automatic test_fill_to_full();
      logic [clq_pkg::WORD_W-1:0] word;
      for (int k = 0; k <= DEPTH; k++) begin
         case (k)
            0: word = 32'h8000_0000;
            1: word = 32'h7FFF_FFFF;
            2: word = 32'h0000_0000;
            3: word = 32'hFFFF_FFFF;
            default: word = $urandom();
         endcase
         send_word(clq_pkg::MODE_ENQUEUE, word);
         maybe_pause();
      end
   endtask

   task automatic test_search_hits();
      send_word(clq_pkg::MODE_SEARCH, shadow_slots[shadow_head]);
      maybe_pause();
      send_word(clq_pkg::MODE_SEARCH, shadow_slots[shadow_tail]);
      maybe_pause();
      send_word(clq_pkg::MODE_SEARCH, 32'h5A5A_A5A5);
      maybe_pause();
   endtask

   // A zero capacity acts as one slot, so the tail is out of reach of a search.
   task automatic test_capacity_limits();
      write_capacity(5'd0);
      send_word(clq_pkg::MODE_DEQUEUE, $urandom());
      maybe_pause();
      send_word(clq_pkg::MODE_SEARCH, shadow_slots[shadow_tail]);
      maybe_pause();
      send_word(clq_pkg::MODE_ENQUEUE, $urandom());
      maybe_pause();
      write_capacity(5'd31);
      send_word(clq_pkg::MODE_DEQUEUE, $urandom());
      maybe_pause();
      send_word(clq_pkg::MODE_SEARCH, shadow_slots[shadow_tail]);
      maybe_pause();
   endtask

   task automatic test_random_traffic();
      logic [clq_pkg::CAP_W-1:0]  phase_cap [10] = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0,
                                                     5'd12, 5'd2, 5'd16, 5'd9, 5'd16};
      logic [clq_pkg::MODE_W-1:0] mode;
      logic [clq_pkg::WORD_W-1:0] word;
      int                         pick;
      int                         enq_bias;
      for (int p = 0; p < 10; p++) begin
         write_capacity(p == 5 ? 5'($urandom_range(1, 31)) : phase_cap[p]);
         gaps_on = (p != 3);
         enq_bias = (p % 2 == 0) ? 70 : 35;
         for (int k = 0; k < 125; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) mode = MODE_UNUSED;
            else if (pick < 28) mode = clq_pkg::MODE_SEARCH;
            else if ($urandom_range(0, 99) < enq_bias) mode = clq_pkg::MODE_ENQUEUE;
            else mode = clq_pkg::MODE_DEQUEUE;
            case ($urandom_range(0, 9))
               0: word = 32'h8000_0000;
               1: word = 32'h7FFF_FFFF;
               2: word = 32'h0000_0000;
               3: word = 32'hFFFF_FFFF;
               default: word = $urandom();
            endcase
            if (mode == clq_pkg::MODE_SEARCH && $urandom_range(0, 99) < 60)
               word = shadow_slots[$urandom_range(0, DEPTH - 1)];
            send_word(mode, word);
            maybe_pause();
         end
      end
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin : check_result
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t: result word with none due: status %0d data %h found %0b",
                     $time, rsp_status, rsp_data_out, rsp_found);
            fail_count++;
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_data_out !== want.data_out) begin
               $display("%0t: data_out expected %h, got %h", $time, want.data_out,
                        rsp_data_out);
               fail_count++;
            end
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %0b, got %0b", $time, want.found, rsp_found);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_to_full();
      test_search_hits();
      test_capacity_limits();
      test_random_traffic();
      start <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/clq_pkg.sv
rtl/clq_cell.sv
rtl/circular_queue_with_search.sv
test/tb_top.sv
